FILE: design/lif_neuron_update_unit_defines.svh
// Assertion macros shared by the neuron update unit.
`ifndef LIF_NEURON_UPDATE_UNIT_DEFINES_SVH
`define LIF_NEURON_UPDATE_UNIT_DEFINES_SVH

// Check that a condition implies another one in the same cycle.
`define LIF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lif: same-cycle check failed");

// Check that a condition implies another one in the following cycle.
`define LIF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lif: next-cycle check failed");

`endif

FILE: design/lif_pkg.sv
// Widths and types for the leaky integrate-and-fire neuron update unit.
package lif_pkg;

    localparam int IDX_W  = 12;
    localparam int DATA_W = 16;

    // Rounding bias for the Q8.24 to Q8.8 step
    localparam int RND_BIAS = 32768;

    typedef logic        [IDX_W-1:0]  t_index;
    typedef logic signed [DATA_W-1:0] t_membrane;
    typedef logic        [DATA_W-1:0] t_beta;

endpackage

FILE: design/lif_neuron_update_unit.sv
// Top level: leaky integrate-and-fire neuron update with a membrane store.
// Items pass stage 1, then the result register; one item per cycle unless the output stalls.
// The store read is registered at acceptance; update and writeback follow as stage 1 advances,
// with the last written entry forwarded to cover back-to-back updates of one neuron.
// Reset: a clearing pass writes zero to each of NUM_NEURONS store entries, one a cycle;
// no input transaction is accepted until it completes.
`include "lif_neuron_update_unit_defines.svh"

module lif_neuron_update_unit #(
    parameter int NUM_NEURONS = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lif_pkg::t_index     i_neuron_index,
    input  lif_pkg::t_membrane  i_input_current,
    input  lif_pkg::t_beta      i_decay_factor,
    input  lif_pkg::t_membrane  i_fire_threshold,
    input  logic                i_use_external,
    input  lif_pkg::t_membrane  i_external_membrane,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lif_pkg::t_index     o_out_index,
    output logic                o_spike,
    output lif_pkg::t_membrane  o_new_membrane
);
    import lif_pkg::*;

    localparam int ADDR_W = (NUM_NEURONS > 1) ? $clog2(NUM_NEURONS) : 1;
    localparam int EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int PROD_W = 2 * DATA_W + 2;
    localparam int LEAK_W = PROD_W - DATA_W;

    // Membrane store
    t_membrane r_mem [NUM_NEURONS];

    // Clearing pass state
    logic              r_clr_active;
    logic [ADDR_W-1:0] r_clr_addr;

    // Stage 1 registers
    logic              r_s1_valid;
    t_index            r_s1_index;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_in_range;
    t_membrane         r_s1_current;
    t_beta             r_s1_beta;
    t_membrane         r_s1_threshold;
    logic              r_s1_use_ext;
    t_membrane         r_s1_ext;
    t_membrane         r_rd_data;

    // Last writeback, forwarded to the next read of the same entry
    logic              r_wb_valid;
    logic [ADDR_W-1:0] r_wb_addr;
    t_membrane         r_wb_data;

    // Result register
    logic              r_out_valid;
    t_index            r_out_index;
    logic              r_out_spike;
    t_membrane         r_out_membrane;

    logic              in_accept;
    logic              s1_advance;
    logic [EXT_W-1:0]  in_idx_ext;
    logic [ADDR_W-1:0] in_addr;
    logic              in_in_range;
    t_membrane         prev;
    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W-1:0] product_rnd;
    logic signed [LEAK_W-1:0] leaked;
    logic signed [LEAK_W-1:0] sum;
    t_membrane         updated;
    logic              n_spike;
    t_membrane         n_stored;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_membrane         mem_wdata;

    // Handshake
    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_active && (!r_s1_valid || s1_advance);
    assign in_accept  = i_in_valid && o_in_ready;

    // Map the neuron index to a store address and range flag
    assign in_idx_ext  = EXT_W'(i_neuron_index);
    assign in_addr     = in_idx_ext[ADDR_W-1:0];
    assign in_in_range = ({1'b0, in_idx_ext} < (EXT_W + 1)'(NUM_NEURONS));

    // Select the previous membrane
    always_comb begin
        if (r_s1_use_ext) begin
            prev = r_s1_ext;
        end else if (!r_s1_in_range) begin
            prev = '0;
        end else if (r_wb_valid && (r_wb_addr == r_s1_addr)) begin
            prev = r_wb_data;
        end else begin
            prev = r_rd_data;
        end
    end

    // Leak, integrate, saturate and compare
    always_comb begin
        product     = PROD_W'($signed({prev[DATA_W-1], prev}) * $signed({1'b0, r_s1_beta}));
        product_rnd = product + PROD_W'(RND_BIAS);
        leaked      = product_rnd[PROD_W-1:DATA_W];
        sum         = leaked + LEAK_W'(r_s1_current);
        if (sum > LEAK_W'(32767)) begin
            updated = t_membrane'(16'sh7FFF);
        end else if (sum < -LEAK_W'(32768)) begin
            updated = t_membrane'(16'sh8000);
        end else begin
            updated = sum[DATA_W-1:0];
        end
        n_spike  = (updated >= r_s1_threshold);
        n_stored = n_spike ? '0 : updated;
    end

    // Share the write port between the clearing pass and writeback
    always_comb begin
        if (r_clr_active) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_advance && r_s1_in_range;
            mem_waddr = r_s1_addr;
            mem_wdata = n_stored;
        end
    end

    // Write and read the store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept && in_in_range) begin
            r_rd_data <= r_mem[in_addr];
        end
    end

    // Sweep the store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == ADDR_W'(NUM_NEURONS - 1)) begin
                r_clr_active <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Capture the transaction into stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_index     <= i_neuron_index;
            r_s1_addr      <= in_addr;
            r_s1_in_range  <= in_in_range;
            r_s1_current   <= i_input_current;
            r_s1_beta      <= i_decay_factor;
            r_s1_threshold <= i_fire_threshold;
            r_s1_use_ext   <= i_use_external;
            r_s1_ext       <= i_external_membrane;
        end
    end

    // Track the last writeback for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else if (!r_clr_active && mem_we) begin
            r_wb_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_clr_active && mem_we) begin
            r_wb_addr <= r_s1_addr;
            r_wb_data <= n_stored;
        end
    end

    // Hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_index    <= r_s1_index;
            r_out_spike    <= n_spike;
            r_out_membrane <= n_stored;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_index    = r_out_index;
    assign o_spike        = r_out_spike;
    assign o_new_membrane = r_out_membrane;

    // Assertions
    `LIF_ASSERT_SAME(a_no_accept_in_clear, r_clr_active, !o_in_ready)
    `LIF_ASSERT_SAME(a_spike_zero_membrane, o_out_valid && o_spike, o_new_membrane == '0)
    `LIF_ASSERT_NEXT(a_accept_fills_s1, in_accept, r_s1_valid)
    `LIF_ASSERT_NEXT(a_s1_holds_on_stall, r_s1_valid && !s1_advance,
        r_s1_valid && $stable(r_s1_index))
    `LIF_ASSERT_NEXT(a_writeback_forwards, !r_clr_active && mem_we,
        r_wb_valid && (r_wb_addr == $past(r_s1_addr)))

endmodule

FILE: verif/tb.sv
// Testbench for the leaky integrate-and-fire neuron update unit.
`timescale 1ns / 100ps

module tb;
    import lif_pkg::*;

    localparam int STORE_DEPTH  = 4096;
    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASE_LEN    = RANDOM_ITEMS / 3;
    localparam int STALL_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct {
        t_index    idx;
        t_membrane cur;
        t_beta     beta;
        t_membrane thr;
        logic      use_ext;
        t_membrane ext_mem;
    } t_update;

    typedef struct {
        t_index    idx;
        logic      spike;
        t_membrane mem;
    } t_result;

    typedef struct {
        t_update upd;
        bit      typed;
        t_result want;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_index    i_neuron_index;
    t_membrane i_input_current;
    t_beta     i_decay_factor;
    t_membrane i_fire_threshold;
    logic      i_use_external;
    t_membrane i_external_membrane;
    logic      o_out_valid;
    logic      i_out_ready;
    t_index    o_out_index;
    logic      o_spike;
    t_membrane o_new_membrane;

    // Tag that travels with the offered payload
    bit        row_typed;
    t_result   row_want;

    t_membrane membrane_copy [STORE_DEPTH];
    t_result   pending_results [$];
    int        mismatches;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        stall_requests;
    int        cycle_count;

    // Directed transactions: extremes, rounding ties, equal threshold, store hazards
    t_row directed_rows [20] = '{
        '{'{12'd0,   16'd0,   16'h8000, 16'd1,   1'b0, 16'd0},   1'b1, '{12'd0,   1'b0, 16'd0}},
        '{'{12'hFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 1'b1, 16'h7FFF}, 1'b1, '{12'hFFF, 1'b1, 16'd0}},
        '{'{12'hFFF, 16'h8000, 16'hFFFF, 16'h8001, 1'b1, 16'h8000}, 1'b1,
          '{12'hFFF, 1'b0, 16'h8000}},
        '{'{12'hFFF, 16'd0,   16'hFFFF, 16'd0,   1'b0, 16'd0},   1'b1, '{12'hFFF, 1'b0, 16'h8001}},
        '{'{12'hFFF, 16'd0,   16'h0000, 16'h8000, 1'b0, 16'd0},  1'b1, '{12'hFFF, 1'b1, 16'd0}},
        '{'{12'd1,   16'd100, 16'h0000, 16'd100, 1'b1, 16'd256}, 1'b1, '{12'd1,   1'b1, 16'd0}},
        '{'{12'd1,   16'd99,  16'h0000, 16'd100, 1'b1, 16'd256}, 1'b1, '{12'd1,   1'b0, 16'd99}},
        '{'{12'd1,   16'd0,   16'hFFFF, 16'h7FFF, 1'b0, 16'd0},  1'b0, '{12'd0,   1'b0, 16'd0}},
        '{'{12'd2,   16'd0,   16'h8000, 16'h7FFF, 1'b1, 16'd1},  1'b0, '{12'd0,   1'b0, 16'd0}},
        '{'{12'd2,   16'd0,   16'h8000, 16'h7FFF, 1'b1, 16'hFFFF}, 1'b0, '{12'd0,  1'b0, 16'd0}},
        '{'{12'd5,   16'h8000, 16'hFFFF, 16'h8000, 1'b0, 16'd0}, 1'b1, '{12'd5,   1'b1, 16'd0}},
        '{'{12'd5,   16'h8000, 16'hFFFF, 16'd0,   1'b0, 16'd0},  1'b1, '{12'd5,   1'b0, 16'h8000}},
        '{'{12'd5,   16'h8000, 16'hFFFF, 16'd0,   1'b0, 16'd0},  1'b1, '{12'd5,   1'b0, 16'h8000}},
        '{'{12'd5,   16'd5,   16'h0000, 16'h7FFF, 1'b1, 16'd1000}, 1'b1, '{12'd5,  1'b0, 16'd5}},
        '{'{12'd5,   16'd0,   16'hFFFF, 16'h7FFF, 1'b0, 16'd0},  1'b0, '{12'd0,   1'b0, 16'd0}},
        '{'{12'd7,   16'd300, 16'h0000, 16'd256, 1'b0, 16'd0},   1'b1, '{12'd7,   1'b1, 16'd0}},
        '{'{12'd7,   16'd200, 16'hFFFF, 16'd256, 1'b0, 16'd0},   1'b1, '{12'd7,   1'b0, 16'd200}},
        '{'{12'd7,   16'd100, 16'hFFFF, 16'd256, 1'b0, 16'd0},   1'b0, '{12'd0,   1'b0, 16'd0}},
        '{'{12'hAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 16'h5555}, 1'b0,
          '{12'd0, 1'b0, 16'd0}},
        '{'{12'h555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 16'hAAAA}, 1'b0,
          '{12'd0, 1'b0, 16'd0}}
    };

    lif_neuron_update_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_neuron_index      (i_neuron_index),
        .i_input_current     (i_input_current),
        .i_decay_factor      (i_decay_factor),
        .i_fire_threshold    (i_fire_threshold),
        .i_use_external      (i_use_external),
        .i_external_membrane (i_external_membrane),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_out_index         (o_out_index),
        .o_spike             (o_spike),
        .o_new_membrane      (o_new_membrane)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Leak, integrate and fire one neuron; update the membrane copy
    function automatic t_result apply_update(t_update u);
        t_membrane         prev;
        t_membrane         upd;
        logic signed [47:0] prod;
        logic signed [47:0] sum;
        t_result           r;
        if (u.use_ext) begin
            prev = u.ext_mem;
        end else if (int'(u.idx) < STORE_DEPTH) begin
            prev = membrane_copy[u.idx];
        end else begin
            prev = '0;
        end
        prod = prev * $signed({1'b0, u.beta}) + 48'sd32768;
        sum  = (prod >>> 16) + u.cur;
        if (sum > 48'sd32767) begin
            upd = 16'h7FFF;
        end else if (sum < -48'sd32768) begin
            upd = 16'h8000;
        end else begin
            upd = sum[15:0];
        end
        r.idx   = u.idx;
        r.spike = (upd >= u.thr);
        r.mem   = r.spike ? t_membrane'(0) : upd;
        if (int'(u.idx) < STORE_DEPTH) begin
            membrane_copy[u.idx] = r.mem;
        end
        return r;
    endfunction

    // Draw one update: mostly a few hot neurons, betas near one, reachable thresholds
    function automatic t_update random_update();
        t_update  u;
        bit [31:0] raw;
        int       v;
        raw = $urandom_range(99);
        if (raw < 55) begin
            raw = $urandom_range(15);
        end else if (raw < 65) begin
            raw = ($urandom_range(1) == 0) ? 32'd0 : 32'hFFF;
        end else begin
            raw = $urandom;
        end
        u.idx = raw[11:0];
        if ($urandom_range(99) < 70) begin
            v = int'($urandom_range(1536)) - 512;
            u.cur = v[15:0];
        end else begin
            raw = $urandom;
            u.cur = raw[15:0];
        end
        raw = $urandom_range(99);
        if (raw < 50) begin
            raw = $urandom_range(65535, 49152);
        end else if (raw < 60) begin
            raw = ($urandom_range(1) == 0) ? 32'd0 : 32'hFFFF;
        end else begin
            raw = $urandom;
        end
        u.beta = raw[15:0];
        raw = ($urandom_range(99) < 60) ? $urandom_range(2048, 128) : $urandom;
        u.thr = raw[15:0];
        u.use_ext = ($urandom_range(99) < 20);
        raw = $urandom;
        u.ext_mem = raw[15:0];
        return u;
    endfunction

    // Offer one transaction at a falling edge and hold it until accepted
    task automatic offer_update(input t_update u, input bit typed, input t_result want);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_neuron_index      <= u.idx;
        i_input_current     <= u.cur;
        i_decay_factor      <= u.beta;
        i_fire_threshold    <= u.thr;
        i_use_external      <= u.use_ext;
        i_external_membrane <= u.ext_mem;
        row_typed           <= typed;
        row_want            <= want;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Lower valid and wait until every expected result has arrived
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Predict on every accepted input transaction
    always @(posedge i_clk) begin
        t_update u;
        t_result r;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            u.idx     = i_neuron_index;
            u.cur     = i_input_current;
            u.beta    = i_decay_factor;
            u.thr     = i_fire_threshold;
            u.use_ext = i_use_external;
            u.ext_mem = i_external_membrane;
            r = apply_update(u);
            pending_results.push_back(row_typed ? row_want : r);
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result index %0d spike %0b membrane %0d",
                         $time, o_out_index, o_spike, o_new_membrane);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_index !== want.idx) begin
                    $display("%0t: index expected %0d actual %0d",
                             $time, want.idx, o_out_index);
                    mismatches++;
                end
                if (o_spike !== want.spike) begin
                    $display("%0t: spike of neuron %0d expected %0b actual %0b",
                             $time, want.idx, want.spike, o_spike);
                    mismatches++;
                end
                if (o_new_membrane !== want.mem) begin
                    $display("%0t: membrane of neuron %0d expected %0d actual %0d",
                             $time, want.idx, want.mem, o_new_membrane);
                    mismatches++;
                end
            end
        end
    end

    // Drive output ready; serve each long hold-off request
    initial begin
        int stalls_served;
        stalls_served = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_requests != stalls_served) begin
                stalls_served++;
                i_out_ready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Reset, directed rows, three random phases, then wait for the tail
    initial begin
        t_result none;
        none                = '{default: '0};
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_neuron_index      = '0;
        i_input_current     = '0;
        i_decay_factor      = '0;
        i_fire_threshold    = '0;
        i_use_external      = 1'b0;
        i_external_membrane = '0;
        row_typed           = 1'b0;
        row_want            = none;
        mismatches          = 0;
        stall_requests      = 0;
        cycle_count         = 0;
        tx_idle_pct         = 25;
        rx_idle_pct         = 48;
        foreach (membrane_copy[n]) begin
            membrane_copy[n] = '0;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            offer_update(directed_rows[r].upd, directed_rows[r].typed, directed_rows[r].want);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == PHASE_LEN) begin
                drain_results();
                tx_idle_pct = 48;
                rx_idle_pct = 25;
            end
            if (k == 2 * PHASE_LEN) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                stall_requests++;
            end
            offer_update(random_update(), 1'b0, none);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
